>>> rtl/tcpq_pkg.sv
`timescale 1ns / 1ps

package tcpq_pkg;

   // Command codes carried by the request.
   typedef enum logic [1:0] {
      CMD_INSERT   = 2'd0,
      CMD_SERVE    = 2'd1,
      CMD_WITHDRAW = 2'd2,
      CMD_LOOKUP   = 2'd3
   } cmd_type;

   // Request transaction payload.
   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] item_id;
      logic        preferred;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic        ok;
      logic [15:0] out_id;
      logic        out_preferred;
      logic [6:0]  count;
   } rsp_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_HEAD_RD,
      ST_HEAD_CAP,
      ST_CLOSE,
      ST_OPEN,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic search;
      logic head_rd;
      logic head_cap;
      logic start_close;
      logic close;
      logic start_open;
      logic open;
      logic mark_ok;
      logic mark_pref;
      logic finish_load;
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cmd_type req_cmd;
      cmd_type cur_cmd;
      logic    full;
      logic    empty;
      logic    search_done;
      logic    hit;
      logic    close_done;
      logic    open_done;
      logic    rsp_free;
   } stat_type;

endpackage

>>> rtl/tcpq_ctrl.sv
`timescale 1ns / 1ps

module tcpq_ctrl import tcpq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output ctl_type  ctl
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (stat.req_cmd)
                  CMD_INSERT:   state_in = stat.full ? ST_FINISH : ST_SEARCH;
                  CMD_SERVE:    state_in = stat.empty ? ST_FINISH : ST_HEAD_RD;
                  CMD_WITHDRAW: state_in = ST_SEARCH;
                  CMD_LOOKUP:   state_in = ST_SEARCH;
                  default:      state_in = ST_FINISH;
               endcase
            end
         end
         ST_SEARCH: begin
            if (stat.search_done) begin
               if (stat.hit && stat.cur_cmd == CMD_WITHDRAW) begin
                  state_in = ST_CLOSE;
               end else if (!stat.hit && stat.cur_cmd == CMD_INSERT) begin
                  state_in = ST_OPEN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_HEAD_RD:  state_in = ST_HEAD_CAP;
         ST_HEAD_CAP: state_in = ST_CLOSE;
         ST_CLOSE: begin
            if (stat.close_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_OPEN: begin
            if (stat.open_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output logic: datapath commands and the request handshake.
   always_comb begin
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            ctl.load_req = req_valid;
         end
         ST_SEARCH: begin
            ctl.search = 1'b1;
            if (stat.search_done && stat.hit) begin
               if (stat.cur_cmd == CMD_WITHDRAW) begin
                  ctl.start_close = 1'b1;
                  ctl.mark_ok     = 1'b1;
               end else if (stat.cur_cmd == CMD_LOOKUP) begin
                  ctl.mark_ok   = 1'b1;
                  ctl.mark_pref = 1'b1;
               end
            end else if (stat.search_done && stat.cur_cmd == CMD_INSERT) begin
               ctl.start_open = 1'b1;
            end
         end
         ST_HEAD_RD: ctl.head_rd = 1'b1;
         ST_HEAD_CAP: begin
            ctl.head_cap    = 1'b1;
            ctl.mark_ok     = 1'b1;
            ctl.start_close = 1'b1;
         end
         ST_CLOSE: ctl.close = 1'b1;
         ST_OPEN: begin
            ctl.open    = 1'b1;
            ctl.mark_ok = stat.open_done;
         end
         ST_FINISH: ctl.finish_load = stat.rsp_free;
         default: ctl = '0;
      endcase
   end

endmodule

>>> rtl/tcpq_dp.sv
`timescale 1ns / 1ps

module tcpq_dp import tcpq_pkg::*; #(
   parameter int DEPTH   = 64,
   parameter int ID_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output rsp_type  rsp_data,
   input  ctl_type  ctl,
   output stat_type stat
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Slot memory: class bit above the id, kept in service order.
   logic [ID_BITS:0] slot_mem_ff [DEPTH];
   logic [ID_BITS:0] rdata_ff;

   // Captured request.
   cmd_type              cmd_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic                 pref_req_ff;

   // Queue occupancy.
   logic [CNT_W-1:0]     total_ff, total_in;
   logic [CNT_W-1:0]     pref_cnt_ff, pref_cnt_in;

   // Walk pointer and read pipeline.
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]    rd_idx_ff;

   // Result under construction and the output register.
   logic                 rm_cls_ff;
   logic                 res_ok_ff;
   logic [15:0]          res_id_ff;
   logic                 res_pref_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff;

   logic [ID_BITS+15:0]  req_id_wide;
   logic [ID_BITS-1:0]   req_id;
   logic [ID_BITS+15:0]  out_id_wide;
   logic [CNT_W+6:0]     cnt_wide;
   logic [CNT_W-1:0]     at_pos;
   logic [CNT_W-1:0]     idx_m1;
   logic [CNT_W-1:0]     close_base;
   logic                 match_now;
   logic                 walk_end;
   logic                 open_done;
   logic                 issue;
   logic                 rd_en;
   logic [ADDR_W-1:0]    raddr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    waddr;
   logic [ID_BITS:0]     wdata;

   // Id width adaptation and count truncation.
   assign req_id_wide = {{ID_BITS{1'b0}}, req_data.item_id};
   assign req_id      = req_id_wide[ID_BITS-1:0];
   assign out_id_wide = {16'b0, rdata_ff[ID_BITS-1:0]};
   assign cnt_wide    = {7'b0, total_ff};

   // Insert position: end of the preferred block or end of the queue.
   assign at_pos = pref_req_ff ? pref_cnt_ff : total_ff;
   assign idx_m1 = idx_ff - 1'b1;

   // Walk status.
   assign match_now = ctl.search && rd_vld_ff && (rdata_ff[ID_BITS-1:0] == id_ff);
   assign walk_end  = !rd_vld_ff && (idx_ff >= total_ff);
   assign open_done = !rd_vld_ff && (idx_ff <= at_pos);

   // Read issue for the search, close and open walks.
   always_comb begin
      issue = 1'b0;
      priority if (ctl.search) begin
         issue = (idx_ff < total_ff) && !match_now;
      end else if (ctl.close) begin
         issue = idx_ff < total_ff;
      end else if (ctl.open) begin
         issue = idx_ff > at_pos;
      end else begin
         issue = 1'b0;
      end
   end

   assign rd_en = issue || ctl.head_rd;

   always_comb begin
      if (ctl.open) begin
         raddr = idx_m1[ADDR_W-1:0];
      end else if (ctl.head_rd) begin
         raddr = '0;
      end else begin
         raddr = idx_ff[ADDR_W-1:0];
      end
   end

   // Write port: shift writes, or the new entry when the gap is open.
   always_comb begin
      wr_en = 1'b0;
      waddr = '0;
      wdata = rdata_ff;
      if (ctl.close && rd_vld_ff) begin
         wr_en = 1'b1;
         waddr = rd_idx_ff - 1'b1;
      end else if (ctl.open && rd_vld_ff) begin
         wr_en = 1'b1;
         waddr = rd_idx_ff + 1'b1;
      end else if (ctl.open && open_done) begin
         wr_en = 1'b1;
         waddr = at_pos[ADDR_W-1:0];
         wdata = {pref_req_ff, id_ff};
      end
   end

   // Slot memory with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= slot_mem_ff[raddr];
      end
   end

   // Walk pointer: reset on a new transaction, reloaded for each walk.
   assign close_base = ctl.head_cap ? '0 : CNT_W'(rd_idx_ff);

   always_comb begin
      idx_in = idx_ff;
      priority if (ctl.load_req) begin
         idx_in = '0;
      end else if (ctl.start_close) begin
         idx_in = close_base + 1'b1;
      end else if (ctl.start_open) begin
         idx_in = total_ff;
      end else if (issue) begin
         idx_in = ctl.open ? idx_m1 : idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   assign rd_vld_in = issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (issue) begin
         rd_idx_ff <= raddr;
      end
   end

   // Occupancy counts change when a gap is filled or closed.
   always_comb begin
      total_in    = total_ff;
      pref_cnt_in = pref_cnt_ff;
      if (ctl.open && open_done) begin
         total_in    = total_ff + 1'b1;
         pref_cnt_in = pref_cnt_ff + CNT_W'(pref_req_ff);
      end else if (ctl.close && walk_end) begin
         total_in    = total_ff - 1'b1;
         pref_cnt_in = pref_cnt_ff - CNT_W'(rm_cls_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         pref_cnt_ff <= '0;
      end else begin
         total_ff    <= total_in;
         pref_cnt_ff <= pref_cnt_in;
      end
   end

   // Request capture and result fields.
   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff      <= req_data.cmd;
         id_ff       <= req_id;
         pref_req_ff <= req_data.preferred;
         res_ok_ff   <= 1'b0;
         res_id_ff   <= '0;
         res_pref_ff <= 1'b0;
      end
      if (match_now) begin
         rm_cls_ff <= rdata_ff[ID_BITS];
      end
      if (ctl.head_cap) begin
         rm_cls_ff   <= rdata_ff[ID_BITS];
         res_id_ff   <= out_id_wide[15:0];
         res_pref_ff <= rdata_ff[ID_BITS];
      end
      if (ctl.mark_pref) begin
         res_pref_ff <= rdata_ff[ID_BITS];
      end
      if (ctl.mark_ok) begin
         res_ok_ff <= 1'b1;
      end
   end

   // Output register; it holds until the transaction is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.finish_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish_load) begin
         rsp_data_ff.ok            <= res_ok_ff;
         rsp_data_ff.out_id        <= res_id_ff;
         rsp_data_ff.out_preferred <= res_pref_ff;
         rsp_data_ff.count         <= cnt_wide[6:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status toward the controller.
   always_comb begin
      stat             = '0;
      stat.req_cmd     = req_data.cmd;
      stat.cur_cmd     = cmd_ff;
      stat.full        = total_ff >= CNT_W'(DEPTH);
      stat.empty       = total_ff == '0;
      stat.search_done = ctl.search && (match_now || walk_end);
      stat.hit         = match_now;
      stat.close_done  = walk_end;
      stat.open_done   = open_done;
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

endmodule

>>> rtl/two_class_priority_queue_core.sv
// One transaction at a time: a new request is taken only after the previous transaction has
// finished and its response has been loaded into a free output register. Each walk over the
// stored slots (search, closing or opening a gap) moves one slot per cycle through the slot
// memory. Reset is synchronous and empties the queue at once; the slot memory is not cleared.
`timescale 1ns / 1ps

module two_class_priority_queue_core import tcpq_pkg::*; #(
   parameter int DEPTH   = 64,
   parameter int ID_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctl_type  ctl;
   stat_type stat;

   // Sequencer.
   tcpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Slot memory, counters and the output register.
   tcpq_dp #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .stat      (stat)
   );

endmodule
